// ===== rtl/bfe_pkg.sv =====
package bfe_pkg;

  localparam int FRAME_WIDTH  = 64;
  localparam int FRAME_HEIGHT = 64;
  localparam int PIX_TOTAL    = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);
  localparam int AW = $clog2(PIX_TOTAL);
  localparam int CW = $clog2(PIX_TOTAL + 1);

  localparam int ACTION_W   = 2;
  localparam int POS_W      = 6;
  localparam int COLOR_W    = 4;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef logic [XW-1:0]      xcoord_t;
  typedef logic [YW-1:0]      ycoord_t;
  typedef logic [AW-1:0]      addr_t;
  typedef logic [CW-1:0]      qcount_t;
  typedef logic [YW+XW-1:0]   qentry_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FILL  = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL     = 1'd1;

  localparam color_t BOUNDARY_RESET = 4'd15;
  localparam color_t FILL_RESET     = 4'd4;

  // neighbour visiting order
  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_WR   = 4'd1;
  localparam step_t S_RD   = 4'd2;
  localparam step_t S_RD2  = 4'd3;
  localparam step_t S_SEED = 4'd4;
  localparam step_t S_NB   = 4'd5;
  localparam step_t S_NB2  = 4'd6;
  localparam step_t S_POP  = 4'd7;
  localparam step_t S_LOAD = 4'd8;
  localparam step_t S_EMIT = 4'd9;

  typedef enum logic [3:0] {
    U_IDLE    = 4'd0,
    U_PIX_WR  = 4'd1,
    U_PIX_RD  = 4'd2,
    U_TAKE    = 4'd3,
    U_SEED    = 4'd4,
    U_NB_RD   = 4'd5,
    U_NB_TEST = 4'd6,
    U_POP     = 4'd7,
    U_LOAD    = 4'd8,
    U_EMIT    = 4'd9
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_DISPATCH = 3'd2,
    C_QEMPTY   = 3'd3,
    C_DIR_MORE = 3'd4,
    C_OUT_FREE = 3'd5
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    logic  hold;
    step_t target;
  } uword_t;

  // control store: jump to target (dispatch jumps to the decoded step) when the condition holds, else stay or step on
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_IDLE:  w = '{uop: U_IDLE,    cond: C_DISPATCH, hold: 1'b1, target: S_IDLE};
      S_WR:    w = '{uop: U_PIX_WR,  cond: C_ALWAYS,   hold: 1'b0, target: S_EMIT};
      S_RD:    w = '{uop: U_PIX_RD,  cond: C_NEXT,     hold: 1'b0, target: S_IDLE};
      S_RD2:   w = '{uop: U_TAKE,    cond: C_ALWAYS,   hold: 1'b0, target: S_EMIT};
      S_SEED:  w = '{uop: U_SEED,    cond: C_ALWAYS,   hold: 1'b0, target: S_POP};
      S_NB:    w = '{uop: U_NB_RD,   cond: C_NEXT,     hold: 1'b0, target: S_IDLE};
      S_NB2:   w = '{uop: U_NB_TEST, cond: C_DIR_MORE, hold: 1'b0, target: S_NB};
      S_POP:   w = '{uop: U_POP,     cond: C_QEMPTY,   hold: 1'b0, target: S_EMIT};
      S_LOAD:  w = '{uop: U_LOAD,    cond: C_ALWAYS,   hold: 1'b0, target: S_NB};
      S_EMIT:  w = '{uop: U_EMIT,    cond: C_OUT_FREE, hold: 1'b1, target: S_IDLE};
      default: w = '{uop: U_IDLE,    cond: C_ALWAYS,   hold: 1'b0, target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic addr_t pix_addr(xcoord_t x, ycoord_t y);
    return addr_t'(y) * addr_t'(FRAME_WIDTH) + addr_t'(x);
  endfunction

  function automatic addr_t q_inc(addr_t a);
    return (a == addr_t'(PIX_TOTAL - 1)) ? '0 : a + addr_t'(1);
  endfunction

endpackage

// ===== rtl/bfe_item_if.sv =====
interface bfe_item_if;
  logic                          valid;
  logic                          ready;
  logic [bfe_pkg::ACTION_W-1:0]  action;
  logic [bfe_pkg::POS_W-1:0]     pos_x;
  logic [bfe_pkg::POS_W-1:0]     pos_y;
  logic [bfe_pkg::COLOR_W-1:0]   write_color;

  modport source (output valid, action, pos_x, pos_y, write_color, input ready);
  modport sink (input valid, action, pos_x, pos_y, write_color, output ready);
endinterface

// ===== rtl/bfe_result_if.sv =====
interface bfe_result_if;
  logic                         valid;
  logic                         ready;
  logic [bfe_pkg::COLOR_W-1:0]  read_color;
  logic [bfe_pkg::COUNT_W-1:0]  painted_count;

  modport source (output valid, read_color, painted_count, input ready);
  modport sink (input valid, read_color, painted_count, output ready);
endinterface

// ===== rtl/boundary_fill_engine.sv =====
// one word at a time: a write passes through S_WR, a read through S_RD and S_RD2, and a
// fill through S_SEED and then S_POP, S_LOAD and S_NB/S_NB2 per neighbour for each queued
// pixel, before S_EMIT registers the result; the next word is taken back in S_IDLE, once
// S_EMIT has handed the result on; the fill rate is set by the frame buffer accesses
// reset is synchronous; afterwards a clearing pass zeroes all 4096 words of the frame
// buffer, during which no word is taken (configuration writes are taken throughout)
module boundary_fill_engine (
  input  logic                              clk,
  input  logic                              rst,
  bfe_item_if.sink                          item,
  bfe_result_if.source                      result,
  input  logic                              cfg_we,
  input  logic [bfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bfe_pkg::color_t  frame_mem [bfe_pkg::PIX_TOTAL];
  bfe_pkg::qentry_t queue_mem [bfe_pkg::PIX_TOTAL];

  bfe_pkg::step_t   step, step_next;
  bfe_pkg::uword_t  uw;
  bfe_pkg::color_t  boundary, fill;
  logic             clearing;
  bfe_pkg::addr_t   clr_addr;

  bfe_pkg::xcoord_t item_x, cur_x, nb_x, nb_x_q;
  bfe_pkg::ycoord_t item_y, cur_y, nb_y, nb_y_q;
  bfe_pkg::color_t  item_wc;
  bfe_pkg::addr_t   item_addr, nb_addr, nb_addr_q;
  bfe_pkg::dir_t    dir;
  logic             nb_ok, nb_ok_q;

  bfe_pkg::addr_t   head, tail;
  bfe_pkg::qcount_t q_count, painted;
  bfe_pkg::color_t  res_color;

  logic             out_valid;
  bfe_pkg::color_t  out_color;
  bfe_pkg::count_t  out_count;

  logic             pix_we;
  bfe_pkg::addr_t   pix_waddr, pix_raddr;
  bfe_pkg::color_t  pix_wdata, pix_rdata;
  logic             q_we;
  bfe_pkg::addr_t   q_waddr;
  bfe_pkg::qentry_t q_wdata, q_rdata;

  logic             accept, in_frame, out_free, q_empty, q_full, nb_paint, jump;
  bfe_pkg::step_t   disp;

  assign uw         = bfe_pkg::ucode(step);
  assign item.ready = !clearing && (step == bfe_pkg::S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;
  assign q_empty    = (q_count == '0);
  assign q_full     = (q_count == bfe_pkg::qcount_t'(bfe_pkg::PIX_TOTAL));
  assign item_addr  = bfe_pkg::pix_addr(item_x, item_y);
  assign nb_paint   = (uw.uop == bfe_pkg::U_NB_TEST) && nb_ok_q &&
                      (pix_rdata != boundary) && (pix_rdata != fill);

  assign result.valid         = out_valid;
  assign result.read_color    = out_color;
  assign result.painted_count = out_count;

  assign in_frame = (int'(item.pos_x) < bfe_pkg::FRAME_WIDTH) &&
                    (int'(item.pos_y) < bfe_pkg::FRAME_HEIGHT);

  always_comb begin
    case (item.action)
      bfe_pkg::ACT_WRITE: disp = bfe_pkg::S_WR;
      bfe_pkg::ACT_READ:  disp = bfe_pkg::S_RD;
      bfe_pkg::ACT_FILL:  disp = bfe_pkg::S_SEED;
      default:            disp = bfe_pkg::S_EMIT;
    endcase
    if (!in_frame) begin
      disp = bfe_pkg::S_EMIT;
    end
  end

  // sequencer
  always_comb begin
    case (uw.cond)
      bfe_pkg::C_NEXT:     jump = 1'b0;
      bfe_pkg::C_ALWAYS:   jump = 1'b1;
      bfe_pkg::C_DISPATCH: jump = accept;
      bfe_pkg::C_QEMPTY:   jump = q_empty;
      bfe_pkg::C_DIR_MORE: jump = (dir != bfe_pkg::DIR_LEFT);
      bfe_pkg::C_OUT_FREE: jump = out_free;
      default:             jump = 1'b0;
    endcase
    if (jump) begin
      step_next = (uw.cond == bfe_pkg::C_DISPATCH) ? disp : uw.target;
    end else if (uw.hold) begin
      step_next = step;
    end else begin
      step_next = bfe_pkg::step_t'(step + 1'b1);
    end
  end

  // neighbour of the current pixel, out of frame counts as boundary
  always_comb begin
    nb_x  = cur_x;
    nb_y  = cur_y;
    nb_ok = 1'b0;
    case (dir)
      bfe_pkg::DIR_DOWN: begin
        nb_ok = (cur_y != bfe_pkg::ycoord_t'(bfe_pkg::FRAME_HEIGHT - 1));
        nb_y  = cur_y + bfe_pkg::ycoord_t'(1);
      end
      bfe_pkg::DIR_UP: begin
        nb_ok = (cur_y != '0);
        nb_y  = cur_y - bfe_pkg::ycoord_t'(1);
      end
      bfe_pkg::DIR_RIGHT: begin
        nb_ok = (cur_x != bfe_pkg::xcoord_t'(bfe_pkg::FRAME_WIDTH - 1));
        nb_x  = cur_x + bfe_pkg::xcoord_t'(1);
      end
      bfe_pkg::DIR_LEFT: begin
        nb_ok = (cur_x != '0);
        nb_x  = cur_x - bfe_pkg::xcoord_t'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_addr = bfe_pkg::pix_addr(nb_x, nb_y);

  // frame buffer port control
  always_comb begin
    pix_we    = 1'b0;
    pix_waddr = item_addr;
    pix_wdata = fill;
    pix_raddr = nb_addr;
    if (clearing) begin
      pix_we    = 1'b1;
      pix_waddr = clr_addr;
      pix_wdata = '0;
    end else begin
      case (uw.uop)
        bfe_pkg::U_PIX_WR: begin
          pix_we    = 1'b1;
          pix_wdata = item_wc;
        end
        bfe_pkg::U_PIX_RD: pix_raddr = item_addr;
        bfe_pkg::U_SEED:   pix_we = 1'b1;
        bfe_pkg::U_NB_TEST: begin
          pix_we    = nb_paint;
          pix_waddr = nb_addr_q;
        end
        default: pix_we = 1'b0;
      endcase
    end
  end

  // coordinate queue port control
  always_comb begin
    if (uw.uop == bfe_pkg::U_SEED) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = {item_y, item_x};
    end else begin
      q_we    = nb_paint && !q_full;
      q_waddr = tail;
      q_wdata = {nb_y_q, nb_x_q};
    end
  end

  always_ff @(posedge clk) begin
    if (pix_we) begin
      frame_mem[pix_waddr] <= pix_wdata;
    end
    pix_rdata <= frame_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rdata <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= bfe_pkg::S_IDLE;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      boundary  <= bfe_pkg::BOUNDARY_RESET;
      fill      <= bfe_pkg::FILL_RESET;
      head      <= '0;
      tail      <= '0;
      q_count   <= '0;
      painted   <= '0;
      dir       <= bfe_pkg::DIR_DOWN;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;

      if (clearing) begin
        clr_addr <= clr_addr + bfe_pkg::addr_t'(1);
        if (clr_addr == bfe_pkg::addr_t'(bfe_pkg::PIX_TOTAL - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          bfe_pkg::REG_BOUNDARY: boundary <= bfe_pkg::color_t'(cfg_data);
          bfe_pkg::REG_FILL:     fill     <= bfe_pkg::color_t'(cfg_data);
          default: ;
        endcase
      end

      if (accept) begin
        item_x    <= bfe_pkg::xcoord_t'(item.pos_x);
        item_y    <= bfe_pkg::ycoord_t'(item.pos_y);
        item_wc   <= item.write_color;
        res_color <= '0;
        painted   <= '0;
      end

      if ((uw.uop == bfe_pkg::U_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (uw.uop)
        bfe_pkg::U_TAKE: res_color <= pix_rdata;
        bfe_pkg::U_SEED: begin
          head    <= '0;
          tail    <= bfe_pkg::q_inc('0);
          q_count <= bfe_pkg::qcount_t'(1);
          painted <= bfe_pkg::qcount_t'(1);
        end
        bfe_pkg::U_NB_RD: begin
          nb_ok_q   <= nb_ok;
          nb_x_q    <= nb_x;
          nb_y_q    <= nb_y;
          nb_addr_q <= nb_addr;
        end
        bfe_pkg::U_NB_TEST: begin
          dir <= bfe_pkg::dir_t'(dir + 2'd1);
          if (nb_paint) begin
            painted <= painted + bfe_pkg::qcount_t'(1);
            if (!q_full) begin
              tail    <= bfe_pkg::q_inc(tail);
              q_count <= q_count + bfe_pkg::qcount_t'(1);
            end
          end
        end
        bfe_pkg::U_POP: begin
          if (!q_empty) begin
            head    <= bfe_pkg::q_inc(head);
            q_count <= q_count - bfe_pkg::qcount_t'(1);
          end
        end
        bfe_pkg::U_LOAD: begin
          cur_x <= q_rdata[bfe_pkg::XW-1:0];
          cur_y <= q_rdata[bfe_pkg::YW+bfe_pkg::XW-1:bfe_pkg::XW];
          dir   <= bfe_pkg::DIR_DOWN;
        end
        bfe_pkg::U_EMIT: begin
          if (out_free) begin
            out_color <= res_color;
            out_count <= bfe_pkg::count_t'(painted);
          end
        end
        default: ;
      endcase
    end
  end

  // queue is always drained by the time a result goes out
  a_queue_drained: assert property (@(posedge clk) disable iff (rst)
    (step == bfe_pkg::S_EMIT) |-> (q_count == '0))
    else $error("queue not empty at result");

  // a painted neighbour always finds room in the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    nb_paint |-> !q_full)
    else $error("push onto full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (step == bfe_pkg::S_EMIT) |-> (painted <= bfe_pkg::qcount_t'(bfe_pkg::PIX_TOTAL)))
    else $error("painted count out of range");

  // clearing pass covers the whole frame buffer
  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clr_addr) == bfe_pkg::addr_t'(bfe_pkg::PIX_TOTAL - 1)))
    else $error("clearing pass ended early");

endmodule
